@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/gchm_pkg.sv @@
// ---------------------------------------------------------------------------
// Gate counter package
// Widths, limits, register indexes, mode codes and the setting clamp of the gate counter.
// ---------------------------------------------------------------------------
package gchm_pkg;

    localparam int GATE_W     = 15;
    localparam int SET_W      = 5;
    localparam int COUNT_W    = 13;
    localparam int MAG_W      = 12;
    localparam int PULSE_W    = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 4;

    localparam logic signed [GATE_W-1:0]  GATE_THRESH = 15'sd1000;
    localparam logic signed [COUNT_W-1:0] COUNT_LIMIT = 13'sd2520;
    localparam logic [PULSE_W-1:0]        PULSE_RESET = 16'd3840;
    localparam logic [SET_W-1:0]          SET_MIN     = 5'd1;
    localparam logic [SET_W-1:0]          SET_MAX     = 5'd16;
    localparam logic [STEP_W-1:0]         LAST_STEP   = 4'(MAG_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 1'd1;

    localparam logic [MODE_W-1:0] MODE_HOLD        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO_RESET  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LATCH       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIGGER     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AUTO_TRIG   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NOT_WINDOW  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_AUTO_NOTWIN = 3'd6;

    function automatic logic [SET_W-1:0] clamp_setting(input logic [SET_W-1:0] v);
        logic [SET_W-1:0] r;
        r = v;
        if (v < SET_MIN) r = SET_MIN;
        else if (v > SET_MAX) r = SET_MAX;
        return r;
    endfunction

endpackage

@@ design/gate_counter_hold_modes_core.sv @@
// ---------------------------------------------------------------------------
// Gate counter with hold modes
// One channel of a gate counter with window, latch and trigger output modes.
// ---------------------------------------------------------------------------
// Each beat is one gate sample. After a beat is accepted the block does edge
// detection and counting, then a bit-serial remainder of the count magnitude by
// the held target (one shared subtract and compare step per cycle), then forms
// the output, waiting while an earlier result is still stalled there. A new
// beat is taken only after the result is formed and the block is idle again.
// The input is not stalled while a finished result waits at the output.
// Configuration writes are taken only while no beat is in progress, and the
// input is held off while a configuration write is offered.
`include "assert_macros.svh"

module gate_counter_hold_modes_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [gchm_pkg::GATE_W-1:0]    gate_level,
    input  logic                                  reset_pulse,
    input  logic [gchm_pkg::SET_W-1:0]            target_count,
    input  logic [gchm_pkg::SET_W-1:0]            hold_count,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  output_high,
    output logic                                  hit_seen,
    output logic signed [gchm_pkg::COUNT_W-1:0]   count_now,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gchm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gchm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gchm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FIN} state_t;

    state_t                      state_reg;
    logic [MODE_W-1:0]           mode_reg;
    logic [PULSE_W-1:0]          pulse_ticks_reg;
    logic                        prev_gate_reg;
    logic signed [COUNT_W-1:0]   count_reg;
    logic [SET_W-1:0]            held_t_reg;
    logic [SET_W-1:0]            held_w_reg;
    logic [PULSE_W-1:0]          pulse_reg;
    logic signed [GATE_W-1:0]    gate_reg;
    logic                        rst_in_reg;
    logic [SET_W-1:0]            tgt_in_reg;
    logic [SET_W-1:0]            hold_in_reg;
    logic                        hit_reg;
    logic [MAG_W-1:0]            mag_reg;
    logic [SET_W-1:0]            rem_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        out_valid_reg;
    logic                        out_high_reg;
    logic                        out_hit_reg;
    logic signed [COUNT_W-1:0]   out_count_reg;

    logic                        in_accept;
    logic                        out_blocked;
    logic                        gate_on;
    logic                        hit_now;
    logic signed [COUNT_W-1:0]   count_a;
    logic signed [COUNT_W-1:0]   count_b;
    logic signed [COUNT_W-1:0]   count_next;
    logic [COUNT_W-1:0]          count_abs;
    logic [PULSE_W-1:0]          pulse_dec;
    logic [SET_W-1:0]            rem_shift;
    logic [SET_W-1:0]            rem_next;
    logic signed [COUNT_W:0]     c_ext;
    logic signed [COUNT_W:0]     t_ext;
    logic signed [COUNT_W:0]     tw_ext;
    logic                        reload;
    logic                        out_high_next;
    logic signed [COUNT_W-1:0]   count_fin;
    logic [PULSE_W-1:0]          pulse_reloaded;
    logic [PULSE_W-1:0]          pulse_fin;

    assign in_stall    = (state_reg != S_IDLE) || cfg_valid;
    assign in_accept   = in_valid && !in_stall;
    assign out_blocked = out_valid_reg && out_stall;
    assign cfg_ready   = (state_reg == S_IDLE);

    assign out_valid   = out_valid_reg;
    assign output_high = out_high_reg;
    assign hit_seen    = out_hit_reg;
    assign count_now   = out_count_reg;

    always_comb
    begin
        gate_on = (gate_reg >= GATE_THRESH);
        hit_now = gate_on && !prev_gate_reg;
        if (rst_in_reg)
        begin
            count_a = (gate_reg > GATE_THRESH) ? '0 : '1;
        end
        else
        begin
            count_a = count_reg;
        end
        count_b    = count_a + $signed({{(COUNT_W-1){1'b0}}, hit_now});
        count_next = (count_b > COUNT_LIMIT) ? COUNT_LIMIT : count_b;
        count_abs  = count_next[COUNT_W-1] ? -count_next : count_next;
        pulse_dec  = (pulse_reg != '0) ? pulse_reg - PULSE_W'(1) : pulse_reg;
    end

    always_comb
    begin
        rem_shift = {rem_reg[SET_W-2:0], mag_reg[MAG_W-1]};
        rem_next  = (rem_shift >= held_t_reg) ? rem_shift - held_t_reg : rem_shift;
    end

    always_comb
    begin
        c_ext          = {count_reg[COUNT_W-1], count_reg};
        t_ext          = $signed({{(COUNT_W+1-SET_W){1'b0}}, held_t_reg});
        tw_ext         = t_ext + $signed({{(COUNT_W+1-SET_W){1'b0}}, held_w_reg});
        reload         = 1'b0;
        out_high_next  = 1'b0;
        count_fin      = count_reg;
        case (mode_reg)
            MODE_HOLD:
            begin
                out_high_next = (c_ext >= t_ext) && (c_ext <= tw_ext);
            end
            MODE_AUTO_RESET:
            begin
                out_high_next = (c_ext >= t_ext);
                if (c_ext >= tw_ext) count_fin = '0;
            end
            MODE_LATCH:
            begin
                out_high_next = (c_ext >= t_ext);
            end
            MODE_TRIGGER:
            begin
                reload = (c_ext == t_ext);
            end
            MODE_AUTO_TRIG:
            begin
                reload = (count_reg != '0) && (rem_reg == '0);
            end
            MODE_NOT_WINDOW:
            begin
                out_high_next = (c_ext < t_ext) || (c_ext > tw_ext);
            end
            MODE_AUTO_NOTWIN:
            begin
                out_high_next = (c_ext < t_ext) || (c_ext > tw_ext);
                if (c_ext >= tw_ext) count_fin = '0;
            end
            default:
            begin
                out_high_next = 1'b0;
            end
        endcase
        pulse_reloaded = (pulse_ticks_reg > pulse_reg) ? pulse_ticks_reg : pulse_reg;
        pulse_fin      = reload ? pulse_reloaded : pulse_reg;
        if (mode_reg == MODE_TRIGGER || mode_reg == MODE_AUTO_TRIG)
        begin
            out_high_next = (pulse_fin != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= MODE_HOLD;
            pulse_ticks_reg <= PULSE_RESET;
            prev_gate_reg   <= 1'b0;
            count_reg       <= '1;
            held_t_reg      <= SET_MIN;
            held_w_reg      <= SET_MIN;
            pulse_reg       <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg        <= cfg_data[MODE_W-1:0];
                    REG_PULSE_TICKS: pulse_ticks_reg <= cfg_data[PULSE_W-1:0];
                    default:         mode_reg        <= mode_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        gate_reg    <= gate_level;
                        rst_in_reg  <= reset_pulse;
                        tgt_in_reg  <= target_count;
                        hold_in_reg <= hold_count;
                        state_reg   <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (rst_in_reg)
                    begin
                        held_t_reg <= clamp_setting(tgt_in_reg);
                        held_w_reg <= clamp_setting(hold_in_reg);
                    end
                    prev_gate_reg <= gate_on;
                    hit_reg       <= hit_now;
                    count_reg     <= count_next;
                    pulse_reg     <= pulse_dec;
                    mag_reg       <= count_abs[MAG_W-1:0];
                    rem_reg       <= '0;
                    step_reg      <= '0;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    mag_reg  <= {mag_reg[MAG_W-2:0], 1'b0};
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_FIN:
                begin
                    if (!out_blocked)
                    begin
                        count_reg     <= count_fin;
                        pulse_reg     <= pulse_fin;
                        if ((hit_reg && !out_high_next) || count_fin == '0)
                        begin
                            held_t_reg <= clamp_setting(tgt_in_reg);
                            held_w_reg <= clamp_setting(hold_in_reg);
                        end
                        out_valid_reg <= 1'b1;
                        out_high_reg  <= out_high_next;
                        out_hit_reg   <= hit_reg;
                        out_count_reg <= count_fin;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, (count_reg >= -13'sd1) && (count_reg <= COUNT_LIMIT), "edge count left its range")
    `ASSERT_ALWAYS(a_held_range, clk, rst_n, (held_t_reg >= SET_MIN) && (held_t_reg <= SET_MAX) && (held_w_reg >= SET_MIN) && (held_w_reg <= SET_MAX), "held setting left 1 to 16")
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_reg == S_PREP, "accepted beat did not start work")
    `ASSERT_NEXT(a_div_steps, clk, rst_n, (state_reg == S_DIV) && (step_reg != LAST_STEP), state_reg == S_DIV, "remainder sequence ended early")

endmodule
